// ===== design/trb_pkg.sv =====
// trb_pkg: shared types and codes for the timestamp reorder buffer
// used by trb_cell and timestamp_reorder_buffer; no dependencies

package trb_pkg;

    localparam int TIME_W   = 64;
    localparam int HANDLE_W = 32;
    localparam int FUNC_W   = 2;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FLUSH  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_DROP   = 2'd2;

    typedef struct packed {
        logic [TIME_W-1:0]   ftime;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic pop;   // every cell takes its upper neighbor
        logic ins;   // insert at pos, cells above take lower neighbor
        logic pos1;  // insert position: 0 or 1
        logic rep;   // head cell is overwritten with the new frame
    } cell_ctrl_t;

endpackage

// ===== design/trb_cell.sv =====
// trb_cell: one slot of the frame chain, holds a timestamp and a handle
// depends on trb_pkg

module trb_cell
    import trb_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     new_entry,
    input  entry_t     lower,
    input  entry_t     upper,
    output entry_t     q
);

    entry_t entry_reg;
    entry_t entry_next;
    int     pos;

    always_comb
    begin
        pos        = ctrl.pos1 ? 1 : 0;
        entry_next = entry_reg;
        if (ctrl.pop)
        begin
            entry_next = upper;
        end
        else if (ctrl.rep && IDX == 0)
        begin
            entry_next = new_entry;
        end
        else if (ctrl.ins)
        begin
            if (IDX == pos)
            begin
                entry_next = new_entry;
            end
            else if (IDX > pos)
            begin
                entry_next = lower;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule

// ===== design/timestamp_reorder_buffer.sv =====
// timestamp_reorder_buffer: top level, command sequencer over a chain of trb_cell slots
// depends on trb_pkg and trb_cell
// result words: the command and the frame are registered when start is taken, then each word
// is registered out of the run state, one word a cycle; busy stays high while the run emits
// words and while an insert places the frame; a new command is taken only after busy falls;
// one compare/shift step per cycle; slot contents kept on reset
module timestamp_reorder_buffer
    import trb_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [FUNC_W-1:0]          func,
    input  logic signed [TIME_W-1:0]   frame_time,
    input  logic [HANDLE_W-1:0]        frame_handle,
    output logic                       strobe,
    output logic signed [TIME_W-1:0]   out_time,
    output logic [HANDLE_W-1:0]        out_handle,
    output logic                       forced,
    output logic                       last_of_run
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              strobe_reg, strobe_next;
    logic              forced_reg, forced_next;
    logic              last_reg, last_next;
    entry_t            word_reg, word_next;
    logic [FUNC_W-1:0] func_reg;
    entry_t            item_reg;
    cell_ctrl_t        ctrl;
    entry_t            q [DEPTH+2];
    logic              full;
    logic              lt_head;
    logic              le_1;
    logic              le_2;

    // two padding slots above the chain keep neighbor reads in range
    assign q[DEPTH]   = '0;
    assign q[DEPTH+1] = '0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        trb_cell #(
            .IDX (i)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .new_entry (item_reg),
            .lower     ((i == 0) ? item_reg : q[(i == 0) ? 0 : i-1]),
            .upper     (q[i+1]),
            .q         (q[i])
        );
    end

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign lt_head = $signed(item_reg.ftime) < $signed(q[0].ftime);
    assign le_1    = $signed(q[1].ftime) <= $signed(item_reg.ftime);
    assign le_2    = $signed(q[2].ftime) <= $signed(item_reg.ftime);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        strobe_next = 1'b0;
        forced_next = 1'b0;
        last_next   = 1'b0;
        word_next   = q[0];
        ctrl        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                case (func_reg)
                    FN_INSERT:
                    begin
                        if (count_reg == '0)
                        begin
                            ctrl.ins   = 1'b1;
                            count_next = count_reg + 1'b1;
                            state_next = ST_IDLE;
                        end
                        else if (lt_head)
                        begin
                            if (full)
                            begin
                                strobe_next = 1'b1;
                                forced_next = 1'b1;
                                last_next   = 1'b1;
                                word_next   = item_reg;
                            end
                            else
                            begin
                                ctrl.ins   = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                            state_next = ST_IDLE;
                        end
                        else if (count_reg >= CNT_W'(2) && le_1)
                        begin
                            // walk: emit head; last only if next slot stops the walk
                            strobe_next = 1'b1;
                            last_next   = !(count_reg >= CNT_W'(3) && le_2);
                            ctrl.pop    = 1'b1;
                            count_next  = count_reg - 1'b1;
                        end
                        else if (full)
                        begin
                            strobe_next = 1'b1;
                            forced_next = 1'b1;
                            last_next   = 1'b1;
                            ctrl.rep    = 1'b1;
                            state_next  = ST_IDLE;
                        end
                        else
                        begin
                            ctrl.ins   = 1'b1;
                            ctrl.pos1  = 1'b1;
                            count_next = count_reg + 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    FN_FLUSH:
                    begin
                        if (count_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            strobe_next = 1'b1;
                            last_next   = (count_reg == CNT_W'(1));
                            ctrl.pop    = 1'b1;
                            count_next  = count_reg - 1'b1;
                            if (count_reg == CNT_W'(1))
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    FN_DROP:
                    begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
            forced_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
            forced_reg <= forced_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        if (state_reg == ST_IDLE && start)
        begin
            func_reg        <= func;
            item_reg.ftime  <= frame_time;
            item_reg.handle <= frame_handle;
        end
    end

    assign busy        = (state_reg == ST_RUN);
    assign strobe      = strobe_reg;
    assign out_time    = $signed(word_reg.ftime);
    assign out_handle  = word_reg.handle;
    assign forced      = forced_reg;
    assign last_of_run = last_reg;

endmodule

// ===== tb/trb_checker.sv =====
`timescale 1ns / 1ps
// trb_checker: watches the command and result ports of timestamp_reorder_buffer,
// predicts every emitted word from its own sorted copy of the store; depends on trb_pkg

module trb_checker
    import trb_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic                     busy,
    input  logic [FUNC_W-1:0]        func,
    input  logic signed [TIME_W-1:0] frame_time,
    input  logic [HANDLE_W-1:0]      frame_handle,
    input  logic                     strobe,
    input  logic signed [TIME_W-1:0] out_time,
    input  logic [HANDLE_W-1:0]      out_handle,
    input  logic                     forced,
    input  logic                     last_of_run,
    output int                       mismatches,
    output int                       frames_due
);

    typedef struct {
        logic signed [TIME_W-1:0] ftime;
        logic [HANDLE_W-1:0]      handle;
        logic                     forced;
        logic                     last;
    } emitted_frame_t;

    logic signed [TIME_W-1:0] held_time [DEPTH];
    logic [HANDLE_W-1:0]      held_handle [DEPTH];
    int                       held_count;
    emitted_frame_t           due_frames [$];
    int                       tally;

    task automatic queue_emit(input logic signed [TIME_W-1:0] t, input logic [HANDLE_W-1:0] h,
                              input logic forced_flag);
        emitted_frame_t w;
        w.ftime  = t;
        w.handle = h;
        w.forced = forced_flag;
        w.last   = 1'b0;
        due_frames.push_back(w);
    endtask

    task automatic emit_head(input logic forced_flag);
        queue_emit(held_time[0], held_handle[0], forced_flag);
        for (int i = 1; i < held_count; i++)
        begin
            held_time[i-1]   = held_time[i];
            held_handle[i-1] = held_handle[i];
        end
        held_count--;
    endtask

    // callers make sure there is room
    task automatic slot_in(input int pos, input logic signed [TIME_W-1:0] t,
                           input logic [HANDLE_W-1:0] h);
        for (int i = held_count; i > pos; i--)
        begin
            held_time[i]   = held_time[i-1];
            held_handle[i] = held_handle[i-1];
        end
        held_time[pos]   = t;
        held_handle[pos] = h;
        held_count++;
    endtask

    task automatic reorder_frame(input logic [FUNC_W-1:0] f, input logic signed [TIME_W-1:0] t,
                                 input logic [HANDLE_W-1:0] h);
        int first;
        first = due_frames.size();
        case (f)
            FN_INSERT:
            begin
                if (held_count == 0)
                    slot_in(0, t, h);
                else if (t < held_time[0])
                begin
                    // a full store pushes the new earliest frame straight out
                    if (held_count >= DEPTH)
                        queue_emit(t, h, 1'b1);
                    else
                        slot_in(0, t, h);
                end
                else
                begin
                    // equal timestamps leave before the new frame
                    while (held_count >= 2 && held_time[1] <= t)
                        emit_head(1'b0);
                    if (held_count >= DEPTH)
                    begin
                        emit_head(1'b1);
                        slot_in(0, t, h);
                    end
                    else
                        slot_in(1, t, h);
                end
            end
            FN_FLUSH:
            begin
                while (held_count > 0)
                    emit_head(1'b0);
            end
            FN_DROP:
                held_count = 0;
            default:
                ;
        endcase
        if (due_frames.size() > first)
            due_frames[$].last = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        emitted_frame_t w;
        if (!rst_n)
        begin
            held_count = 0;
            due_frames.delete();
            tally = 0;
            mismatches <= 0;
            frames_due <= 0;
        end
        else
        begin
            // results of earlier words first, a new word's results come later
            if (strobe)
            begin
                if (due_frames.size() == 0)
                begin
                    $error("unexpected word: out_time %0d out_handle %h", out_time, out_handle);
                    tally++;
                end
                else
                begin
                    w = due_frames.pop_front();
                    if (out_time !== w.ftime)
                    begin
                        $error("out_time: expected %0d, actual %0d", w.ftime, out_time);
                        tally++;
                    end
                    if (out_handle !== w.handle)
                    begin
                        $error("out_handle: expected %h, actual %h", w.handle, out_handle);
                        tally++;
                    end
                    if (forced !== w.forced)
                    begin
                        $error("forced: expected %b, actual %b", w.forced, forced);
                        tally++;
                    end
                    if (last_of_run !== w.last)
                    begin
                        $error("last_of_run: expected %b, actual %b", w.last, last_of_run);
                        tally++;
                    end
                end
            end
            if (start && !busy)
                reorder_frame(func, frame_time, frame_handle);
            mismatches <= tally;
            frames_due <= due_frames.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: directed and random command words for timestamp_reorder_buffer, final verdict
// depends on trb_pkg, timestamp_reorder_buffer and trb_checker

module tb_top;
    import trb_pkg::*;

    localparam int DEPTH      = 16;
    localparam int ITEMS      = 360;
    localparam int QUIET_TAIL = 60;

    localparam logic [FUNC_W-1:0] FN_UNUSED = 2'd3;

    localparam longint T_MIN = 64'sh8000_0000_0000_0000;
    localparam longint T_MAX = 64'sh7fff_ffff_ffff_ffff;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [FUNC_W-1:0]        func;
    logic signed [TIME_W-1:0] frame_time;
    logic [HANDLE_W-1:0]      frame_handle;
    logic                     strobe;
    logic signed [TIME_W-1:0] out_time;
    logic [HANDLE_W-1:0]      out_handle;
    logic                     forced;
    logic                     last_of_run;
    int                       mismatches;
    int                       frames_due;
    int                       sent;

    timestamp_reorder_buffer #(.DEPTH(DEPTH)) uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .frame_time   (frame_time),
        .frame_handle (frame_handle),
        .strobe       (strobe),
        .out_time     (out_time),
        .out_handle   (out_handle),
        .forced       (forced),
        .last_of_run  (last_of_run)
    );

    trb_checker #(.DEPTH(DEPTH)) u_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .frame_time   (frame_time),
        .frame_handle (frame_handle),
        .strobe       (strobe),
        .out_time     (out_time),
        .out_handle   (out_handle),
        .forced       (forced),
        .last_of_run  (last_of_run),
        .mismatches   (mismatches),
        .frames_due   (frames_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #400_000;
        $display("timestamp_reorder_buffer: mismatch");
        $finish;
    end

    // start stays high into the next word unless an idle burst follows
    task automatic send_word(input logic [FUNC_W-1:0] f, input longint t,
                             input logic [HANDLE_W-1:0] h);
        start        <= 1'b1;
        func         <= f;
        frame_time   <= t;
        frame_handle <= h;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (f != FN_UNUSED)
            sent++;
        if (sent < ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    initial
    begin
        longint base;
        longint t;
        int     kind;
        int     len;
        sent         = 0;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        func         <= FN_INSERT;
        frame_time   <= '0;
        frame_handle <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store: nothing comes out
        send_word(FN_FLUSH, 0, 0);
        send_word(FN_DROP, 0, 0);
        send_word(FN_UNUSED, T_MAX, '1);
        // extremes, earlier-than-head, equal timestamp placed after the head
        send_word(FN_INSERT, T_MAX, 32'hffff_ffff);
        send_word(FN_INSERT, T_MIN, 32'h0000_0000);
        send_word(FN_INSERT, T_MIN, 32'h5555_aaaa);
        send_word(FN_FLUSH, 0, 0);
        // fill to depth, then the two forced cases and a long walk
        for (int i = 0; i < DEPTH; i++)
            send_word(FN_INSERT, 100 - i, 32'h1000 + i);
        send_word(FN_INSERT, 50, 32'haaaa_5555);
        send_word(FN_INSERT, 100 - DEPTH + 1, 32'hdead_0001);
        send_word(FN_INSERT, 200, 32'hdead_0002);
        send_word(FN_DROP, 0, 0);

        base = longint'({$urandom, $urandom}) >>> 4;
        while (sent < ITEMS)
        begin
            kind = $urandom_range(0, 19);
            if (kind < 10)
            begin
                // frames arriving slightly out of order
                len = $urandom_range(4, 24);
                t = base;
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 7) != 0)
                        t = base + longint'($urandom_range(0, 31)) - 16;
                    base += longint'($urandom_range(0, 6));
                    send_word(FN_INSERT, t, $urandom);
                end
            end
            else if (kind < 14)
            begin
                // descending burst, so the store can fill and overflow
                len = $urandom_range(10, 22);
                t = base - longint'($urandom_range(0, 10));
                for (int i = 0; i < len; i++)
                begin
                    send_word(FN_INSERT, t, $urandom);
                    t -= longint'($urandom_range(0, 3));
                end
            end
            else if (kind < 16)
            begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_word(FN_UNUSED, longint'({$urandom, $urandom}), $urandom);
                    else
                        send_word(FN_INSERT, longint'({$urandom, $urandom}), $urandom);
                end
            end
            else if (kind < 19)
                send_word(FN_FLUSH, longint'({$urandom, $urandom}), $urandom);
            else
                send_word(FN_DROP, longint'({$urandom, $urandom}), $urandom);
        end
        start <= 1'b0;

        @(posedge clk);
        while (frames_due != 0 || busy)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0 && frames_due == 0)
            $display("timestamp_reorder_buffer: match");
        else
            $display("timestamp_reorder_buffer: mismatch");
        $finish;
    end

endmodule
